// ===== src/lchab_to_linear_rgb_assert.svh =====
// assertion macros shared by the lch to rgb checker
`ifndef LCHAB_TO_LINEAR_RGB_ASSERT_SVH
`define LCHAB_TO_LINEAR_RGB_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define LCH2RGB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define LCH2RGB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/lch2rgb_pkg.sv =====
// constants and types for the lch(ab) to linear rgb converter
package lch2rgb_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_WHITE_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WHITE_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WHITE_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EPSILON   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_L_THRESH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_KAPPA = 3'd5;

  localparam logic [16:0] WHITE_X_RST   = 17'd62290;
  localparam logic [16:0] WHITE_Y_RST   = 17'd65536;
  localparam logic [16:0] WHITE_Z_RST   = 17'd71357;
  localparam logic [23:0] EPSILON_RST   = 24'd148578;
  localparam logic [14:0] L_THRESH_RST  = 15'd2048;
  localparam logic [23:0] INV_KAPPA_RST = 24'd18573;

  // odd sine polynomial over a quarter turn
  localparam logic [30:0] SIN_C1 = 31'd1686629713;
  localparam logic [30:0] SIN_C3 = 31'd693598669;
  localparam logic [30:0] SIN_C5 = 31'd85569306;
  localparam logic [30:0] SIN_C7 = 31'd5026995;
  localparam logic [30:0] SIN_C9 = 31'd172273;

  // reciprocals for exact floor division: /29 (shift 35), /125 (shift 37), /25 (shift 34)
  localparam logic [30:0] RECIP_29  = 31'd1184818565;
  localparam logic [30:0] RECIP_125 = 31'd1099511628;
  localparam logic [29:0] RECIP_25  = 30'd687194768;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  localparam int PIPE_DEPTH = 18;

  typedef logic signed [26:0] mat_coef_t;

  localparam mat_coef_t RGB_MAT [9] = '{
     27'sd54365800, -27'sd25788905,  -27'sd8363969,
    -27'sd16261585,  27'sd31474238,    27'sd697194,
       27'sd933541,  -27'sd3422987,  27'sd17737295
  };

endpackage

// ===== src/lch2rgb_if.sv =====
// stream interfaces for lch pixels in and linear rgb pixels out
interface lch2rgb_in_if;
  logic        valid;
  logic        ready;
  logic [14:0] lightness;
  logic [15:0] chroma;
  logic [15:0] hue_angle;

  modport source (output valid, lightness, chroma, hue_angle, input ready);
  modport sink   (input valid, lightness, chroma, hue_angle, output ready);
endinterface

interface lch2rgb_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] red;
  logic signed [15:0] green;
  logic signed [15:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

// ===== src/lchab_to_linear_rgb.sv =====
// Converts one CIE LCh(ab) pixel per clock to linear sRGB with a D65 matrix and a
// programmable reference white. The datapath is an 18-stage pipeline that accepts a
// new pixel every cycle unless it is stalled. The pipeline advances as a whole; when
// out_ch holds a result that is not taken, every stage holds and in_ch.ready drops, so
// the sustained rate is one pixel per cycle as long as the sink keeps ready high.
// Configuration writes on the cfg_ port take effect at the next edge and belong only
// to quiet periods of the stream.
module lchab_to_linear_rgb (
  input  logic                                clk,
  input  logic                                rst_n,
  lch2rgb_in_if.sink                          in_ch,
  lch2rgb_out_if.source                       out_ch,
  input  logic                                cfg_we,
  input  logic [lch2rgb_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [lch2rgb_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lch2rgb_pkg::*;

  localparam int NS = PIPE_DEPTH;

  logic [16:0] wx_r, wy_r, wz_r;
  logic [23:0] eps_r, ik_r;
  logic [14:0] lt_r;

  logic [NS:1] vld_r;
  logic        en;

  logic [14:0] lig_r  [1:11];
  logic [15:0] chr_r  [1:7];
  logic [1:0]  quad_r [1:7];
  logic [14:0] xs_r   [1:6][2];
  logic [14:0] x2_r   [2:5][2];
  logic [30:0] p_r    [3:6][2];
  logic [46:0] fyp_r;
  logic [24:0] fy_r   [3:9];
  logic [16:0] s_r    [2];
  logic signed [33:0] a_r, b_r;
  logic [60:0] qap_r;
  logic [58:0] qbp_r;
  logic        na_r, nb_r;
  logic signed [26:0] f_r [3];
  logic signed [26:0] f11_r [3];
  logic signed [53:0] sq_r [3];
  logic signed [33:0] lin_r [2];
  logic [38:0] ylp_r;
  logic signed [54:0] cub_r [3];
  logic signed [58:0] linp_r [2];
  logic [30:0] ylin_r;
  logic        ysel_r;
  logic signed [33:0] r13_r [3];
  logic signed [35:0] xyz_r [3];
  logic signed [45:0] pl_r [9];
  logic signed [44:0] ph_r [9];
  logic signed [63:0] t_r [9];
  logic signed [63:0] acc_r [3];
  logic signed [15:0] rgb_r [3];

  logic [16:0]        s_nxt [2];
  logic signed [17:0] sn_nxt, cs_nxt;
  logic [33:0]        ma_nxt, mb_nxt;
  logic [23:0]        qa_nxt;
  logic [24:0]        qb_nxt;
  logic signed [26:0] f_nxt [3];
  logic signed [33:0] r13_nxt [3];
  logic signed [51:0] wp_nxt [3];
  logic [16:0]        wsel [3];
  logic signed [28:0] sat_nxt [3];
  logic signed [15:0] rgb_nxt [3];

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wx_r  <= WHITE_X_RST;
      wy_r  <= WHITE_Y_RST;
      wz_r  <= WHITE_Z_RST;
      eps_r <= EPSILON_RST;
      lt_r  <= L_THRESH_RST;
      ik_r  <= INV_KAPPA_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_WHITE_X:   wx_r  <= cfg_data[16:0];
        REG_WHITE_Y:   wy_r  <= cfg_data[16:0];
        REG_WHITE_Z:   wz_r  <= cfg_data[16:0];
        REG_EPSILON:   eps_r <= cfg_data;
        REG_L_THRESH:  lt_r  <= cfg_data[14:0];
        REG_INV_KAPPA: ik_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // whole pipeline moves together; the last stage is the output register
  assign en          = !vld_r[NS] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-1:1], in_ch.valid};
    end
  end

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      logic [17:0] sraw;
      sraw     = 18'((46'(p_r[6][j]) * 46'(xs_r[6][j])) >> 28);
      s_nxt[j] = (sraw > 18'd65536) ? 17'd65536 : sraw[16:0];
    end

    case (quad_r[7])
      QUAD_0: begin
        sn_nxt = $signed({1'b0, s_r[0]});
        cs_nxt = $signed({1'b0, s_r[1]});
      end
      QUAD_1: begin
        sn_nxt = $signed({1'b0, s_r[1]});
        cs_nxt = -$signed({1'b0, s_r[0]});
      end
      QUAD_2: begin
        sn_nxt = -$signed({1'b0, s_r[0]});
        cs_nxt = -$signed({1'b0, s_r[1]});
      end
      default: begin
        sn_nxt = -$signed({1'b0, s_r[1]});
        cs_nxt = $signed({1'b0, s_r[0]});
      end
    endcase

    ma_nxt = a_r[33] ? 34'(-a_r) : 34'(a_r);
    mb_nxt = b_r[33] ? 34'(-b_r) : 34'(b_r);

    // quotients truncate toward zero: magnitude divided, sign put back
    qa_nxt = 24'(qap_r >> 37);
    qb_nxt = 25'(qbp_r >> 34);
    f_nxt[1] = $signed({2'b00, fy_r[9]});
    f_nxt[0] = na_r ? f_nxt[1] - $signed({3'b000, qa_nxt})
                    : f_nxt[1] + $signed({3'b000, qa_nxt});
    f_nxt[2] = nb_r ? f_nxt[1] + $signed({2'b00, qb_nxt})
                    : f_nxt[1] - $signed({2'b00, qb_nxt});

    r13_nxt[0] = (31'(cub_r[0] >>> 24) > $signed({7'd0, eps_r}))
                 ? 34'(cub_r[0] >>> 24) : 34'(linp_r[0] >>> 24);
    r13_nxt[1] = ysel_r ? 34'(cub_r[1] >>> 24) : $signed({3'b000, ylin_r});
    r13_nxt[2] = (31'(cub_r[2] >>> 24) > $signed({7'd0, eps_r}))
                 ? 34'(cub_r[2] >>> 24) : 34'(linp_r[1] >>> 24);

    wsel[0] = wx_r;
    wsel[1] = wy_r;
    wsel[2] = wz_r;
    for (int j = 0; j < 3; j++) begin
      wp_nxt[j]  = 52'(r13_r[j]) * 52'($signed({1'b0, wsel[j]}));
      sat_nxt[j] = 29'(acc_r[j] >>> 35);
      if (sat_nxt[j] > 29'sd32767) begin
        rgb_nxt[j] = 16'sh7FFF;
      end else if (sat_nxt[j] < -29'sd32768) begin
        rgb_nxt[j] = -16'sh8000;
      end else begin
        rgb_nxt[j] = sat_nxt[j][15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: capture
      lig_r[1]    <= in_ch.lightness;
      chr_r[1]    <= in_ch.chroma;
      quad_r[1]   <= in_ch.hue_angle[15:14];
      xs_r[1][0]  <= 15'(in_ch.hue_angle[13:0]);
      xs_r[1][1]  <= 15'd16384 - 15'(in_ch.hue_angle[13:0]);
      for (int k = 2; k <= 11; k++) lig_r[k] <= lig_r[k-1];
      for (int k = 2; k <= 7; k++) begin
        chr_r[k]  <= chr_r[k-1];
        quad_r[k] <= quad_r[k-1];
      end
      for (int k = 2; k <= 6; k++) xs_r[k] <= xs_r[k-1];
      for (int k = 3; k <= 5; k++) x2_r[k] <= x2_r[k-1];
      for (int k = 4; k <= 9; k++) fy_r[k] <= fy_r[k-1];

      // stages 2 to 7: sine and cosine, horner steps
      for (int j = 0; j < 2; j++) begin
        x2_r[2][j] <= 15'((30'(xs_r[1][j]) * 30'(xs_r[1][j])) >> 14);
        p_r[3][j]  <= SIN_C7 - 31'((46'(SIN_C9) * 46'(x2_r[2][j])) >> 14);
        p_r[4][j]  <= SIN_C5 - 31'((46'(p_r[3][j]) * 46'(x2_r[3][j])) >> 14);
        p_r[5][j]  <= SIN_C3 - 31'((46'(p_r[4][j]) * 46'(x2_r[4][j])) >> 14);
        p_r[6][j]  <= SIN_C1 - 31'((46'(p_r[5][j]) * 46'(x2_r[5][j])) >> 14);
        s_r[j]     <= s_nxt[j];
      end
      // fy = ((lightness + 4096) << 16) / 116
      fyp_r   <= 47'(16'(lig_r[1]) + 16'd4096) * 47'(RECIP_29);
      fy_r[3] <= 25'(fyp_r >> 21);

      // stage 8: a and b
      a_r <= 34'($signed({1'b0, chr_r[7]}) * cs_nxt);
      b_r <= 34'($signed({1'b0, chr_r[7]}) * sn_nxt);

      // stage 9: a / 500 and b / 200 by reciprocal
      qap_r <= 61'(ma_nxt[31:2]) * 61'(RECIP_125);
      qbp_r <= 59'(mb_nxt[31:3]) * 59'(RECIP_25);
      na_r  <= a_r[33];
      nb_r  <= b_r[33];

      // stage 10: f values
      f_r <= f_nxt;

      // stage 11: squares and linear segments
      for (int j = 0; j < 3; j++) sq_r[j] <= 54'(f_r[j]) * 54'(f_r[j]);
      lin_r[0] <= 34'(f_r[0]) * 34'sd116 - 34'sd268435456;
      lin_r[1] <= 34'(f_r[2]) * 34'sd116 - 34'sd268435456;
      ylp_r    <= 39'(lig_r[10]) * 39'(ik_r);
      f11_r    <= f_r;

      // stage 12: cubes and kappa scaling
      for (int j = 0; j < 3; j++) cub_r[j] <= 55'(sq_r[j] >>> 24) * 55'(f11_r[j]);
      linp_r[0] <= 59'(lin_r[0]) * 59'($signed({1'b0, ik_r}));
      linp_r[1] <= 59'(lin_r[1]) * 59'($signed({1'b0, ik_r}));
      ylin_r    <= 31'(ylp_r >> 8);
      ysel_r    <= lig_r[11] > lt_r;

      // stage 13: segment select
      r13_r <= r13_nxt;

      // stage 14: reference white
      for (int j = 0; j < 3; j++) xyz_r[j] <= 36'(wp_nxt[j] >>> 16);

      // stage 15: matrix partial products, xyz split in two halves
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          pl_r[3*k+j] <= 46'(RGB_MAT[3*k+j]) * 46'($signed({1'b0, xyz_r[j][17:0]}));
          ph_r[3*k+j] <= 45'(RGB_MAT[3*k+j]) * 45'($signed(xyz_r[j][35:18]));
        end
      end

      // stage 16: recombine halves
      for (int i = 0; i < 9; i++) t_r[i] <= (64'(ph_r[i]) <<< 18) + 64'(pl_r[i]);

      // stage 17: row sums with rounding bias
      for (int k = 0; k < 3; k++) begin
        acc_r[k] <= t_r[3*k] + t_r[3*k+1] + t_r[3*k+2] + 64'sd17179869184;
      end

      // stage 18: round and saturate into the output register
      rgb_r <= rgb_nxt;
    end
  end

  assign out_ch.valid = vld_r[NS];
  assign out_ch.red   = rgb_r[0];
  assign out_ch.green = rgb_r[1];
  assign out_ch.blue  = rgb_r[2];

endmodule

// ===== src/lch2rgb_chk.sv =====
// port-level checks for the lch to rgb converter, bound to the top level
module lch2rgb_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] red,
  input logic [15:0] green,
  input logic [15:0] blue
);
`include "lchab_to_linear_rgb_assert.svh"

  // a waiting result stays put until taken
  `LCH2RGB_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(red) && $stable(green) && $stable(blue), "result changed while stalled")

  // input side only backs up behind an untaken result
  `LCH2RGB_ASSERT_IMP(a_in_free, !out_valid, in_ready, "input stalled with empty output")

  `LCH2RGB_ASSERT_IMP(a_in_flow, out_ready, in_ready, "input stalled while sink is ready")

  // an untaken result holds the whole pipeline
  `LCH2RGB_ASSERT_IMP(a_in_hold, out_valid && !out_ready, !in_ready, "input taken behind a stalled result")

endmodule

bind lchab_to_linear_rgb lch2rgb_chk u_lch2rgb_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .red       (out_ch.red),
  .green     (out_ch.green),
  .blue      (out_ch.blue)
);

// ===== bench/lch2rgb_tb_if.sv =====
// the testbench drives the stream interfaces defined with the rtl in lch2rgb_if.sv

// ===== bench/tb_top.sv =====
// testbench for the lch(ab) to linear rgb converter with a built-in pixel predictor
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lch2rgb_pkg::*;

  typedef struct packed {
    logic signed [15:0] red;
    logic signed [15:0] green;
    logic signed [15:0] blue;
  } rgb_t;

  localparam int LATENCY = PIPE_DEPTH + 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  lch2rgb_in_if in_ch ();
  lch2rgb_out_if out_ch ();

  lchab_to_linear_rgb dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor copy of the registers
  longint wx, wy, wz, eps_thr, l_thr, inv_k;
  rgb_t expected_rgb[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit sink_stalls = 1'b1;
  bit src_gaps = 1'b1;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.lightness = '0;
    in_ch.chroma = '0;
    in_ch.hue_angle = '0;
    out_ch.ready = 1'b0;
  end

  function automatic longint floor_shr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint qsine(longint x);
    longint x2, p, s;
    x2 = (x * x) >>> 14;
    p = SIN_C9;
    p = longint'(SIN_C7) - ((p * x2) >>> 14);
    p = longint'(SIN_C5) - ((p * x2) >>> 14);
    p = longint'(SIN_C3) - ((p * x2) >>> 14);
    p = longint'(SIN_C1) - ((p * x2) >>> 14);
    s = (p * x) >>> 28;
    return (s > 65536) ? 65536 : s;
  endfunction

  function automatic longint cube_q24(longint f);
    return floor_shr(floor_shr(f * f, 24) * f, 24);
  endfunction

  function automatic longint inv_f(longint f);
    longint c;
    c = cube_q24(f);
    if (c > eps_thr) return c;
    return floor_shr((116 * f - (longint'(16) << 24)) * inv_k, 24);
  endfunction

  function automatic logic signed [15:0] round_sat(longint acc);
    longint v;
    v = floor_shr(acc + (longint'(1) << 34), 35);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic rgb_t predict_rgb(logic [14:0] l_in, logic [15:0] c_in,
                                       logic [15:0] h_in);
    longint lig, chr, frac, s0, s1, sn, cs, a, b, fy, fx, fz, yr;
    longint xyz[3];
    longint acc[3];
    rgb_t r;
    lig = l_in;
    chr = c_in;
    frac = h_in[13:0];
    s0 = qsine(frac);
    s1 = qsine(16384 - frac);
    case (h_in[15:14])
      QUAD_0: begin sn = s0; cs = s1; end
      QUAD_1: begin sn = s1; cs = -s0; end
      QUAD_2: begin sn = -s0; cs = -s1; end
      default: begin sn = -s1; cs = s0; end
    endcase
    a = chr * cs;
    b = chr * sn;
    fy = ((lig + 4096) <<< 16) / 116;
    fx = fy + a / 500;
    fz = fy - b / 200;
    if (lig > l_thr) yr = cube_q24(fy);
    else yr = (lig * inv_k) >>> 8;
    xyz[0] = floor_shr(inv_f(fx) * wx, 16);
    xyz[1] = floor_shr(yr * wy, 16);
    xyz[2] = floor_shr(inv_f(fz) * wz, 16);
    for (int k = 0; k < 3; k++)
      acc[k] = longint'(RGB_MAT[3*k]) * xyz[0] + longint'(RGB_MAT[3*k+1]) * xyz[1]
             + longint'(RGB_MAT[3*k+2]) * xyz[2];
    r.red = round_sat(acc[0]);
    r.green = round_sat(acc[1]);
    r.blue = round_sat(acc[2]);
    return r;
  endfunction

  task automatic send_pixel(logic [14:0] l_in, logic [15:0] c_in, logic [15:0] h_in);
    int gap;
    if (src_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 7);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.lightness <= l_in;
    in_ch.chroma <= c_in;
    in_ch.hue_angle <= h_in;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_rgb.push_back(predict_rgb(l_in, c_in, h_in));
  endtask

  task automatic end_burst();
    in_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    end_burst();
    @(posedge clk);
    while (expected_rgb.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_WHITE_X: wx = val & 'h1FFFF;
      REG_WHITE_Y: wy = val & 'h1FFFF;
      REG_WHITE_Z: wz = val & 'h1FFFF;
      REG_EPSILON: eps_thr = val & 'hFFFFFF;
      REG_L_THRESH: l_thr = val & 'h7FFF;
      REG_INV_KAPPA: inv_k = val & 'hFFFFFF;
      default: ;
    endcase
  endtask

  task automatic load_defaults();
    write_reg(REG_WHITE_X, WHITE_X_RST);
    write_reg(REG_WHITE_Y, WHITE_Y_RST);
    write_reg(REG_WHITE_Z, WHITE_Z_RST);
    write_reg(REG_EPSILON, EPSILON_RST);
    write_reg(REG_L_THRESH, L_THRESH_RST);
    write_reg(REG_INV_KAPPA, INV_KAPPA_RST);
  endtask

  task automatic send_random(int n);
    logic [14:0] l;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: l = 15'($urandom_range(0, 4096));
        1: l = 15'($urandom_range(0, 25600));
        default: l = 15'($urandom);
      endcase
      send_pixel(l, 16'($urandom), 16'($urandom));
    end
  endtask

  task automatic test_directed();
    logic [15:0] hues[8] = '{16'h0000, 16'h3FFF, 16'h4000, 16'h8000, 16'hC000,
                            16'hFFFF, 16'h2000, 16'hA000};
    send_pixel(15'd0, 16'd0, 16'd0);
    send_pixel(15'd25600, 16'd0, 16'd0);
    send_pixel(15'h7FFF, 16'hFFFF, 16'hFFFF);
    send_pixel(15'd2048, 16'd0, 16'd0);
    send_pixel(15'd2049, 16'd0, 16'd0);
    for (int i = 0; i < 8; i++) send_pixel(15'd12800, 16'hFFFF, hues[i]);
    for (int i = 0; i < 4; i++) send_pixel(15'd1000, 16'd20000, hues[i*2]);
    send_pixel(15'd25600, 16'hFFFF, 16'h5555);
    send_pixel(15'd0, 16'hFFFF, 16'hAAAA);
    drain();
  endtask

  task automatic test_random_default();
    send_random(400);
    // hold off until the pipeline is empty
    drain();
  endtask

  task automatic test_register_sweep();
    write_reg(REG_WHITE_X, 0);
    write_reg(REG_WHITE_Y, 'h1FFFF);
    write_reg(REG_WHITE_Z, 'h1FFFF);
    write_reg(REG_EPSILON, 0);
    write_reg(REG_L_THRESH, 25600);
    write_reg(REG_INV_KAPPA, 'hFFFFFF);
    send_random(150);
    drain();
    write_reg(REG_WHITE_X, 'h1FFFF);
    write_reg(REG_WHITE_Y, 0);
    write_reg(REG_WHITE_Z, 0);
    write_reg(REG_EPSILON, 'hFFFFFF);
    write_reg(REG_L_THRESH, 0);
    write_reg(REG_INV_KAPPA, 0);
    send_random(150);
    drain();
    write_reg(REG_WHITE_X, $urandom_range(0, 'h1FFFF));
    write_reg(REG_WHITE_Y, $urandom_range(0, 'h1FFFF));
    write_reg(REG_WHITE_Z, $urandom_range(0, 'h1FFFF));
    write_reg(REG_EPSILON, $urandom_range(0, 'hFFFFFF));
    write_reg(REG_L_THRESH, $urandom_range(0, 25600));
    write_reg(REG_INV_KAPPA, $urandom_range(0, 'hFFFFFF));
    write_reg(REG_UNUSED, 'hFFFFFF);
    send_random(150);
    drain();
    load_defaults();
  endtask

  task automatic test_full_rate();
    src_gaps = 1'b0;
    sink_stalls = 1'b0;
    send_random(280);
    drain();
  endtask

  // sink side: random stall bursts on ready
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      if (sink_stalls && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 7);
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    rgb_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.red, out_ch.green, out_ch.blue};
      if (expected_rgb.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected rgb transaction %h", got);
      end else begin
        want = expected_rgb.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("rgb mismatch: expected r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                     want.red, want.green, want.blue, got.red, got.green, got.blue);
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    wx = WHITE_X_RST; wy = WHITE_Y_RST; wz = WHITE_Z_RST;
    eps_thr = EPSILON_RST; l_thr = L_THRESH_RST; inv_k = INV_KAPPA_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_default();
    test_register_sweep();
    test_full_rate();
    if (mismatches == 0 && expected_rgb.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+src
src/lch2rgb_pkg.sv
src/lch2rgb_if.sv
src/lchab_to_linear_rgb.sv
src/lch2rgb_chk.sv
bench/lch2rgb_tb_if.sv
bench/tb_top.sv
